>>> rtl/lgs_pkg.sv
`timescale 1ns / 1ps
package lgs_pkg;

  localparam int CFG_W    = 11;
  localparam int COORD_W  = 10;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;
  localparam int MIN_DIM  = 3;
  localparam int DIM_RESET = 64;
  localparam int OUT_DEPTH = 3;

  localparam logic REG_BOARD_WIDTH  = 1'b0;
  localparam logic REG_BOARD_HEIGHT = 1'b1;

  // Per-item control that travels from the raster stage to the window stage.
  typedef struct packed {
    logic               stream_cell;
    logic               emit;
    logic               border;
    logic               last;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } lgs_tag_t;

  typedef struct packed {
    logic               next_cell;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } lgs_result_t;

endpackage

>>> rtl/lgs_ram.sv
`timescale 1ns / 1ps
module lgs_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> rtl/lgs_raster.sv
`timescale 1ns / 1ps
module lgs_raster #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         restart_i,
  input  logic [lgs_pkg::CFG_W-1:0]    cfg_width_i,
  input  logic [lgs_pkg::CFG_W-1:0]    cfg_height_i,
  input  logic                         accept_i,
  input  logic                         kind_i,
  input  logic                         cell_in_i,
  output logic [$clog2(MAX_WIDTH)-1:0] rd_addr_o,
  output lgs_pkg::lgs_tag_t            tag_o
);
  import lgs_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int HW = $clog2(MAX_HEIGHT);

  typedef enum logic [1:0] {RowFirst, RowSecond, RowSteady} row_phase_e;

  row_phase_e    phase_q, phase_d;
  logic [CW-1:0] in_col_q, in_col_d;
  logic [HW-1:0] emit_row_q, emit_row_d;
  logic [CW-1:0] emit_col_q, emit_col_d;

  logic [31:0]   w_use, h_use;
  logic [CW-1:0] w_m1;
  logic [HW-1:0] h_m1;
  logic          col_last, emitting, row_end, col_end, border, last;

  // Dimensions in use are clamped to the legal range.
  always_comb begin
    if (cfg_width_i < CFG_W'(MIN_DIM)) begin
      w_use = 32'(MIN_DIM);
    end else if (32'(cfg_width_i) > 32'(MAX_WIDTH)) begin
      w_use = 32'(MAX_WIDTH);
    end else begin
      w_use = 32'(cfg_width_i);
    end
    if (cfg_height_i < CFG_W'(MIN_DIM)) begin
      h_use = 32'(MIN_DIM);
    end else if (32'(cfg_height_i) > 32'(MAX_HEIGHT)) begin
      h_use = 32'(MAX_HEIGHT);
    end else begin
      h_use = 32'(cfg_height_i);
    end
  end

  assign w_m1 = CW'(w_use - 32'd1);
  assign h_m1 = HW'(h_use - 32'd1);

  assign col_last = (in_col_q == w_m1);
  assign emitting = (phase_q == RowSteady) || ((phase_q == RowSecond) && (in_col_q != '0));
  assign row_end  = (emit_row_q >= h_m1);
  assign col_end  = (emit_col_q >= w_m1);
  assign border   = (emit_row_q == '0) || row_end || (emit_col_q == '0) || col_end;
  assign last     = emitting && row_end && col_end;

  assign rd_addr_o         = in_col_q;
  assign tag_o.stream_cell = kind_i ? 1'b0 : cell_in_i;
  assign tag_o.emit        = emitting;
  assign tag_o.border      = border;
  assign tag_o.last        = last;
  assign tag_o.row         = COORD_W'(emit_row_q);
  assign tag_o.col         = COORD_W'(emit_col_q);

  always_comb begin
    phase_d    = phase_q;
    in_col_d   = in_col_q;
    emit_row_d = emit_row_q;
    emit_col_d = emit_col_q;
    if (restart_i || (accept_i && last)) begin
      phase_d    = RowFirst;
      in_col_d   = '0;
      emit_row_d = '0;
      emit_col_d = '0;
    end else if (accept_i) begin
      if (col_last) begin
        in_col_d = '0;
        case (phase_q)
          RowFirst:  phase_d = RowSecond;
          RowSecond: phase_d = RowSteady;
          default:   phase_d = RowSteady;
        endcase
      end else begin
        in_col_d = in_col_q + CW'(1);
      end
      if (emitting) begin
        if (col_end) begin
          emit_col_d = '0;
          emit_row_d = emit_row_q + HW'(1);
        end else begin
          emit_col_d = emit_col_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= RowFirst;
      in_col_q   <= '0;
      emit_row_q <= '0;
      emit_col_q <= '0;
    end else begin
      phase_q    <= phase_d;
      in_col_q   <= in_col_d;
      emit_row_q <= emit_row_d;
      emit_col_q <= emit_col_d;
    end
  end

  a_in_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_col_q <= w_m1) else $error("input column beyond board width");
  a_emit_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_col_q <= w_m1) else $error("emit column beyond board width");
  a_emit_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_row_q <= h_m1) else $error("emit row beyond board height");

endmodule

>>> rtl/lgs_window.sv
`timescale 1ns / 1ps
module lgs_window #(
  parameter int AW = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  restart_i,
  input  logic                  accept_i,
  input  logic [AW-1:0]         rd_addr_i,
  input  lgs_pkg::lgs_tag_t     tag_i,
  input  logic [1:0]            ram_rdata_i,
  output logic                  ram_we_o,
  output logic [AW-1:0]         ram_waddr_o,
  output logic [1:0]            ram_wdata_o,
  output logic                  push_o,
  output lgs_pkg::lgs_result_t  result_o
);
  import lgs_pkg::*;

  logic          valid_q;
  lgs_tag_t      tag_q;
  logic [AW-1:0] addr_q;
  logic          fwd_q;
  logic [1:0]    fwd_data_q;
  logic [8:0]    win_q, win_n;
  logic [1:0]    line;
  logic          nt, nm, center, value;
  logic [3:0]    count;

  // Line data: bit 1 is the row two above the input, bit 0 the row above.
  assign line = fwd_q ? fwd_data_q : ram_rdata_i;
  assign nt   = line[1];
  assign nm   = line[0];

  assign win_n  = {tag_q.stream_cell, win_q[8:7], nm, win_q[5:4], nt, win_q[2:1]};
  assign center = win_n[4];
  assign count  = 4'(win_n[0]) + 4'(win_n[1]) + 4'(win_n[2]) + 4'(win_n[3])
                + 4'(win_n[5]) + 4'(win_n[6]) + 4'(win_n[7]) + 4'(win_n[8]);
  assign value  = tag_q.border ? center : ((count == 4'd3) || ((count == 4'd2) && center));

  assign ram_we_o    = valid_q;
  assign ram_waddr_o = addr_q;
  assign ram_wdata_o = {nm, tag_q.stream_cell};

  assign push_o             = valid_q && tag_q.emit;
  assign result_o.next_cell = value;
  assign result_o.row       = tag_q.row;
  assign result_o.col       = tag_q.col;
  assign result_o.last      = tag_q.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      fwd_q   <= 1'b0;
      win_q   <= '0;
    end else begin
      valid_q <= accept_i;
      // A read that meets a write to the same column sees the new data.
      fwd_q   <= accept_i && valid_q && (addr_q == rd_addr_i);
      if (restart_i) begin
        win_q <= '0;
      end else if (valid_q) begin
        win_q <= tag_q.last ? '0 : win_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      tag_q  <= tag_i;
      addr_q <= rd_addr_i;
    end
    fwd_data_q <= ram_wdata_o;
  end

endmodule

>>> rtl/lgs_out_fifo.sv
`timescale 1ns / 1ps
module lgs_out_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lgs_pkg::lgs_result_t data_i,
  input  logic                 pending_i,
  output logic                 room_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output lgs_pkg::lgs_result_t data_o
);
  import lgs_pkg::*;

  localparam int PW = $clog2(OUT_DEPTH);
  localparam int NW = $clog2(OUT_DEPTH + 1);

  lgs_result_t   mem_q [OUT_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [NW-1:0] cnt_q;
  logic          pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign pop     = valid_o && ready_i;
  // Room for the result still in the window stage and one more item.
  assign room_o  = (32'(cnt_q) + 32'(pending_i)) <= 32'(OUT_DEPTH - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(OUT_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(OUT_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + NW'(1);
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= 32'(OUT_DEPTH)) else $error("result queue count overflow");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (32'(cnt_q) < 32'(OUT_DEPTH)) || pop)
    else $error("result pushed into a full queue");

endmodule

>>> rtl/life_generation_stencil.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_ready_o  kind_i, cell_in_i
// out       output     out_valid_o / out_ready_i next_cell_o, out_row_o, out_col_o, frame_last_o
// config    input      APB psel/penable/pwrite  paddr, pwdata, prdata (pready tied high)
//
// One input item is taken per clock while in_ready_o is high. Each item passes the
// raster stage (line buffer read issued) and the window stage (read data used, line
// buffer written back); the result of an emitting item is then written into the result queue.
// The single line buffer RAM sets the input rate: one read and one write per cycle.
// Reset clears positions, window and queue; line buffer contents are undefined
// until written and get no clearing pass.
// A three-entry result queue absorbs output stalls; in_ready_o falls when the queue,
// counting the result in the window stage, has no room for one more item.
module life_generation_stencil #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Cell stream in.
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         kind_i,
  input  logic                         cell_in_i,
  // Next generation out.
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         next_cell_o,
  output logic [lgs_pkg::COORD_W-1:0]  out_row_o,
  output logic [lgs_pkg::COORD_W-1:0]  out_col_o,
  output logic                         frame_last_o,
  // Configuration.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lgs_pkg::APB_AW-1:0]   paddr,
  input  logic [lgs_pkg::APB_DW-1:0]   pwdata,
  output logic [lgs_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import lgs_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  logic [CFG_W-1:0] width_q, height_q;
  logic             cfg_wr;
  logic             accept;
  logic [AW-1:0]    rd_addr;
  lgs_tag_t         tag;
  logic [1:0]       ram_rdata, ram_wdata;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic             push, room;
  lgs_result_t      result, head;

  // Configuration port. Any write restarts the frame; keep the block idle then (not enforced).
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[2])
      REG_BOARD_WIDTH:  prdata = APB_DW'(width_q);
      REG_BOARD_HEIGHT: prdata = APB_DW'(height_q);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(DIM_RESET);
      height_q <= CFG_W'(DIM_RESET);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_BOARD_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
        REG_BOARD_HEIGHT: height_q <= pwdata[CFG_W-1:0];
        default:          width_q  <= width_q;
      endcase
    end
  end

  assign in_ready_o = room;
  assign accept     = in_valid_i && in_ready_o;

  // Raster stage: input position, emit position and border decisions.
  lgs_raster #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_raster (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .restart_i    (cfg_wr),
    .cfg_width_i  (width_q),
    .cfg_height_i (height_q),
    .accept_i     (accept),
    .kind_i       (kind_i),
    .cell_in_i    (cell_in_i),
    .rd_addr_o    (rd_addr),
    .tag_o        (tag)
  );

  // Both line buffers share one RAM word per column: {upper, middle}.
  lgs_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // Window stage: 3x3 shift, B3/S23 rule (border cells kept) and line buffer write-back.
  lgs_window #(
    .AW (AW)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (cfg_wr),
    .accept_i    (accept),
    .rd_addr_i   (rd_addr),
    .tag_i       (tag),
    .ram_rdata_i (ram_rdata),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .push_o      (push),
    .result_o    (result)
  );

  // Result queue decouples the output transfer from the pipeline.
  lgs_out_fifo u_out_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .data_i    (result),
    .pending_i (push),
    .room_o    (room),
    .valid_o   (out_valid_o),
    .ready_i   (out_ready_i),
    .data_o    (head)
  );

  assign next_cell_o  = head.next_cell;
  assign out_row_o    = head.row;
  assign out_col_o    = head.col;
  assign frame_last_o = head.last;

endmodule
